@@ rtl/core/acsi_pkg.sv @@
//------------------------------------------------------------------------------
// acsi_pkg
// shared constants, codes and types of the ansi csi text console
//------------------------------------------------------------------------------
`default_nettype none
package acsi_pkg;
	localparam int ScreenRows = 25;
	localparam int ScreenCols = 80;
	localparam int RowW = 5;
	localparam int ColW = 7;
	localparam int ParamW = 16;
	localparam logic [ParamW-1:0] ParamMax = 16'hFFFF;
	localparam logic [7:0] ChEsc = 8'd27;
	localparam logic [7:0] ChLbr = 8'h5B;
	localparam logic [7:0] ChSemi = 8'h3B;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] DefaultAttrRst = 8'd15;
	localparam logic [RowW-1:0] LastRow = RowW'(ScreenRows);
	localparam logic [ColW-1:0] LastCol = ColW'(ScreenCols);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_ESC  = 4'b0010,
		PH_P1   = 4'b0100,
		PH_P2   = 4'b1000
	} phase_t;

	// classified operation handed from front to back
	typedef enum logic [3:0] {
		OP_CELL, OP_UP, OP_DOWN, OP_RIGHT, OP_LEFT, OP_NEXTL, OP_PREVL,
		OP_COL, OP_POS, OP_ED, OP_EL, OP_SGR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       glyph;
		logic [ParamW-1:0] p1;
		logic [ParamW-1:0] p2;
	} cmd_t;

	localparam int CmdW = $bits(cmd_t);

	function automatic logic [ParamW-1:0] add_digit(logic [ParamW-1:0] p, logic [3:0] d);
		logic [20:0] v;
		v = 21'(p) * 21'd10 + 21'(d);
		return (v > 21'(ParamMax)) ? ParamMax : v[ParamW-1:0];
	endfunction

	function automatic logic [7:0] fg_code(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h08;
			3'd1: r = 8'h0C;
			3'd2: r = 8'h0A;
			3'd3: r = 8'h0E;
			3'd4: r = 8'h09;
			3'd5: r = 8'h0D;
			3'd6: r = 8'h0B;
			default: r = 8'h0F;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] bg_code(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h00;
			3'd1: r = 8'h40;
			3'd2: r = 8'h20;
			3'd3: r = 8'h60;
			3'd4: r = 8'h10;
			3'd5: r = 8'h50;
			3'd6: r = 8'h30;
			default: r = 8'h70;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/acsi_parser.sv @@
//------------------------------------------------------------------------------
// acsi_parser
// front part: escape sequence parse and classification of each byte
//------------------------------------------------------------------------------
`default_nettype none
module acsi_parser import acsi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] text_byte,
	output logic            in_stall,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  wire logic       cmd_ready
);
	phase_t phase_q, phase_d;
	logic [ParamW-1:0] p1_q, p2_q, p1_d, p2_d;
	logic digit, take, emit;
	op_t fop;
	logic fknown;

	assign digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
	assign in_stall = !cmd_ready;
	assign take = in_valid && cmd_ready;

	always_comb begin
		fknown = 1'b1;
		fop = OP_SGR;
		case (text_byte)
			8'h41: fop = OP_UP;
			8'h42: fop = OP_DOWN;
			8'h43: fop = OP_RIGHT;
			8'h44: fop = OP_LEFT;
			8'h45: fop = OP_NEXTL;
			8'h46: fop = OP_PREVL;
			8'h47: fop = OP_COL;
			8'h48: fop = OP_POS;
			8'h66: fop = OP_POS;
			8'h4A: fop = OP_ED;
			8'h4B: fop = OP_EL;
			8'h6D: fop = OP_SGR;
			default: fknown = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		p1_d = p1_q;
		p2_d = p2_q;
		emit = 1'b0;
		cmd = '{op: OP_CELL, glyph: text_byte, p1: p1_q, p2: p2_q};
		case (phase_q)
			PH_P1: begin
				if (digit) p1_d = add_digit(p1_q, text_byte[3:0]);
				else if (text_byte == ChSemi) phase_d = PH_P2;
				else begin
					phase_d = PH_IDLE;
					emit = fknown;
					cmd.op = fop;
				end
			end
			PH_P2: begin
				if (digit) p2_d = add_digit(p2_q, text_byte[3:0]);
				else begin
					phase_d = PH_IDLE;
					emit = fknown;
					cmd.op = fop;
				end
			end
			default: begin
				if (phase_q == PH_ESC && text_byte == ChLbr) begin
					phase_d = PH_P1;
					p1_d = '0;
					p2_d = '0;
				end else if (text_byte == ChEsc) begin
					phase_d = PH_ESC;
				end else begin
					phase_d = PH_IDLE;
					emit = 1'b1;
				end
			end
		endcase
	end

	assign cmd_valid = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			p1_q <= '0;
			p2_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			p1_q <= p1_d;
			p2_q <= p2_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/acsi_queue.sv @@
//------------------------------------------------------------------------------
// acsi_queue
// two-entry command queue between parser and executor
//------------------------------------------------------------------------------
`default_nettype none
module acsi_queue import acsi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      not_full,
	output logic      pop_valid,
	output cmd_t      pop_cmd,
	input  wire logic pop
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign not_full = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop && pop_valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop && pop_valid);
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/acsi_exec.sv @@
//------------------------------------------------------------------------------
// acsi_exec
// back part: cursor, attribute and result register
//------------------------------------------------------------------------------
`default_nettype none
module acsi_exec import acsi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  wire logic [7:0]  dflt_attr,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [RowW-1:0]  start_row,
	output logic [ColW-1:0]  start_col,
	output logic [RowW-1:0]  end_row,
	output logic [ColW-1:0]  end_col,
	output logic [7:0]       glyph,
	output logic [7:0]       cell_attr
);
	logic [RowW-1:0] row_q, row_d;
	logic [ColW-1:0] col_q, col_d;
	logic [7:0] attr_q, attr_d;
	logic go, res, valid_q;
	logic [RowW-1:0] r0, r1;
	logic [ColW-1:0] c0, c1;
	logic kd;
	logic [7:0] gl;
	logic [17:0] rsum, csum;
	logic [17:0] rdif, cdif;
	logic [ParamW-1:0] n, m;

	assign n = cmd.p1;
	assign m = cmd.p2;
	assign out_valid = valid_q;
	assign go = cmd_valid && (!valid_q || !out_stall);
	assign cmd_pop = go;

	function automatic logic [RowW-1:0] crow(logic [17:0] v);
		return (v == 18'd0) ? RowW'(1) : (v > 18'(ScreenRows)) ? LastRow : v[RowW-1:0];
	endfunction
	function automatic logic [ColW-1:0] ccol(logic [17:0] v);
		return (v == 18'd0) ? ColW'(1) : (v > 18'(ScreenCols)) ? LastCol : v[ColW-1:0];
	endfunction

	always_comb begin
		rsum = 18'(row_q) + 18'(n);
		csum = 18'(col_q) + 18'(n);
		// below one collapses to zero so the clamp gives one
		rdif = (18'(n) >= 18'(row_q)) ? 18'd0 : 18'(row_q) - 18'(n);
		cdif = (18'(n) >= 18'(col_q)) ? 18'd0 : 18'(col_q) - 18'(n);
		row_d = row_q;
		col_d = col_q;
		attr_d = attr_q;
		res = 1'b0;
		kd = 1'b1;
		gl = ChSpace;
		r0 = row_q; c0 = col_q; r1 = row_q; c1 = col_q;
		case (cmd.op)
			OP_CELL: begin
				res = 1'b1;
				kd = 1'b0;
				gl = cmd.glyph;
				col_d = ccol(18'(col_q) + 18'd1);
			end
			OP_UP: row_d = crow(rdif);
			OP_DOWN: row_d = crow(rsum);
			OP_RIGHT: col_d = ccol(csum);
			OP_LEFT: col_d = ccol(cdif);
			OP_NEXTL: begin row_d = crow(rsum); col_d = ColW'(1); end
			OP_PREVL: begin row_d = crow(rdif); col_d = ColW'(1); end
			OP_COL: col_d = ccol(18'(n));
			OP_POS: begin row_d = crow(18'(n)); col_d = ccol(18'(m)); end
			OP_ED: begin
				res = (n <= 16'd2);
				if (n == 16'd0) begin r1 = LastRow; c1 = LastCol; end
				else if (n == 16'd1) begin r0 = RowW'(1); c0 = ColW'(1); end
				else begin r0 = RowW'(1); c0 = ColW'(1); r1 = LastRow; c1 = LastCol; end
			end
			OP_EL: begin
				res = (n <= 16'd2);
				if (n == 16'd0) c1 = LastCol;
				else if (n == 16'd1) c0 = ColW'(1);
				else begin c0 = ColW'(1); c1 = LastCol; end
			end
			OP_SGR: begin
				if (n == 16'd0) attr_d = dflt_attr;
				else if (n == 16'd7) attr_d = {1'b0, attr_q[2:0], 1'b1, attr_q[6:4]};
				else if (n >= 16'd30 && n <= 16'd37)
					attr_d = (attr_q & 8'hF0) | fg_code(n[2:0] - 3'd6);
				else if (n == 16'd39) attr_d = (attr_q & 8'hF0) | fg_code(3'd7);
				else if (n >= 16'd40 && n <= 16'd47) attr_d = (attr_q & 8'h8F) | bg_code(n[2:0]);
				else if (n == 16'd49) attr_d = attr_q & 8'h8F;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= RowW'(1);
			col_q <= ColW'(1);
			attr_q <= DefaultAttrRst;
			valid_q <= 1'b0;
		end else begin
			if (go) begin
				row_q <= row_d;
				col_q <= col_d;
				attr_q <= attr_d;
				valid_q <= res;
			end else if (!out_stall) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res) begin
			kind <= kd;
			start_row <= r0;
			start_col <= c0;
			end_row <= r1;
			end_col <= c1;
			glyph <= gl;
			cell_attr <= attr_q;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/ansi_csi_text_console_unit.sv @@
//------------------------------------------------------------------------------
// ansi_csi_text_console_unit
// byte-serial ansi csi text console front end
//------------------------------------------------------------------------------
// One text byte is taken every cycle while the two-entry command queue has
// room; each command is held in the queue and then taken by the executor.
// The parser classifies bytes; the executor updates cursor and attribute at
// one command per cycle while out_stall is low: one byte per clock sustained.
`default_nettype none
module ansi_csi_text_console_unit import acsi_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [7:0]      text_byte,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [7:0]      cfg_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 kind,
	output logic [RowW-1:0]      start_row,
	output logic [ColW-1:0]      start_col,
	output logic [RowW-1:0]      end_row,
	output logic [ColW-1:0]      end_col,
	output logic [7:0]           glyph,
	output logic [7:0]           cell_attr
);
	logic [7:0] dflt_attr_q;
	logic push, nfull, qv, pop;
	cmd_t pcmd, qcmd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dflt_attr_q <= DefaultAttrRst;
		else if (cfg_valid) dflt_attr_q <= cfg_data;
	end

	acsi_parser u_parser (
		.clk, .arst_n, .in_valid, .text_byte, .in_stall,
		.cmd_valid(push), .cmd(pcmd), .cmd_ready(nfull)
	);

	acsi_queue u_queue (
		.clk, .arst_n, .push, .push_cmd(pcmd), .not_full(nfull),
		.pop_valid(qv), .pop_cmd(qcmd), .pop
	);

	acsi_exec u_exec (
		.clk, .arst_n, .cmd_valid(qv), .cmd(qcmd), .cmd_pop(pop),
		.dflt_attr(dflt_attr_q), .out_valid, .out_stall, .kind,
		.start_row, .start_col, .end_row, .end_col, .glyph, .cell_attr
	);

	a_cursor_row: assert property (@(posedge clk) disable iff (!arst_n)
		u_exec.row_q >= RowW'(1) && u_exec.row_q <= LastRow) else $error("row out of range");
	a_cursor_col: assert property (@(posedge clk) disable iff (!arst_n)
		u_exec.col_q >= ColW'(1) && u_exec.col_q <= LastCol) else $error("col out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> nfull) else $error("queue overflow");
endmodule
`default_nettype wire
